// ===== hw/rtl/vspi_pkg.sv =====
package vspi_pkg;

    // Number of velocity channels: three linear and three angular components.
    localparam int NUM_CH = 6;

    // Step count register: width and value after reset.
    localparam int                  STEP_COUNT_W     = 7;
    localparam logic [STEP_COUNT_W-1:0] STEP_COUNT_RESET = 7'd10;

    // Control strobes from the sequencer to every channel lane.
    typedef struct packed {
        logic load;      // capture a new target and start the run
        logic bypass;    // zero step count: the target becomes the previous value at once
        logic div_step;  // one bit of the serial division
        logic step;      // advance to the next setpoint
        logic commit;    // last setpoint taken: the target becomes the previous value
    } t_lane_ctrl;

endpackage

// ===== hw/rtl/vspi_div.sv =====
module vspi_div #(
    parameter int DW = 17,
    parameter int NW = 7
) (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic          i_step,
    input  logic [DW-1:0] i_dividend,
    input  logic [NW-1:0] i_divisor,
    output logic [DW-1:0] o_quot,
    output logic [NW-1:0] o_rem
);

    logic [DW-1:0] r_dvd;
    logic [NW-1:0] r_rem;
    logic [NW:0]   w_shift;
    logic [NW:0]   w_sub;
    logic          w_qbit;

    // One restoring step: bring down the next dividend bit and try the subtraction.
    assign w_shift = {r_rem, r_dvd[DW-1]};
    assign w_qbit  = (w_shift >= {1'b0, i_divisor});
    assign w_sub   = w_shift - {1'b0, i_divisor};

    // The quotient bits shift into the dividend register as its bits are used up.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (i_step) begin
            r_dvd <= {r_dvd[DW-2:0], w_qbit};
            r_rem <= w_qbit ? w_sub[NW-1:0] : w_shift[NW-1:0];
        end
    end

    assign o_quot = r_dvd;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/vspi_lane.sv =====
module vspi_lane #(
    parameter int VW = 16,
    parameter int NW = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  vspi_pkg::t_lane_ctrl   i_ctrl,
    input  logic [NW-1:0]          i_n,
    input  logic signed [VW-1:0]   i_target,
    output logic [VW-1:0]          o_value
);

    logic signed [VW-1:0] r_prev;
    logic signed [VW-1:0] r_tgt;
    logic                 r_neg;
    logic [VW:0]          r_q;
    logic [NW-1:0]        r_r;

    logic [VW:0]          w_delta;
    logic [VW:0]          w_mag;
    logic [VW:0]          w_quot;
    logic [NW-1:0]        w_rem;
    logic [NW:0]          w_sum;
    logic [NW:0]          w_sub;
    logic                 w_ge;
    logic [NW-1:0]        w_r_next;
    logic [VW:0]          w_q_next;
    logic [VW:0]          w_sq;
    logic [VW:0]          w_val;

    // Distance from the previous setpoint to the target, and its magnitude.
    assign w_delta = {i_target[VW-1], i_target} - {r_prev[VW-1], r_prev};
    assign w_mag   = w_delta[VW] ? (~w_delta + (VW+1)'(1)) : w_delta;

    // Serial division of the magnitude by the step count.
    vspi_div #(
        .DW (VW + 1),
        .NW (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_load     (i_ctrl.load),
        .i_step     (i_ctrl.div_step),
        .i_dividend (w_mag),
        .i_divisor  (i_n),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Each step adds the quotient and carries the remainder, so that r_q
    // follows floor(k * |delta| / n) without a multiplier.
    assign w_sum    = {1'b0, r_r} + {1'b0, w_rem};
    assign w_ge     = (w_sum >= {1'b0, i_n});
    assign w_sub    = w_sum - {1'b0, i_n};
    assign w_r_next = w_ge ? w_sub[NW-1:0] : w_sum[NW-1:0];
    assign w_q_next = r_q + w_quot + {{VW{1'b0}}, w_ge};

    // Apply the sign of the distance: truncation toward zero.
    assign w_sq    = r_neg ? (~w_q_next + (VW+1)'(1)) : w_q_next;
    assign w_val   = {r_prev[VW-1], r_prev} + w_sq;
    assign o_value = w_val[VW-1:0];

    // Previous setpoint, zero after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_ctrl.load && i_ctrl.bypass) begin
            r_prev <= i_target;
        end else if (i_ctrl.commit) begin
            r_prev <= r_tgt;
        end
    end

    // Target and running quotient of the current run.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_tgt <= i_target;
            r_neg <= w_delta[VW];
            r_q   <= '0;
            r_r   <= '0;
        end else if (i_ctrl.step) begin
            r_q   <= w_q_next;
            r_r   <= w_r_next;
        end
    end

endmodule

// ===== hw/rtl/velocity_setpoint_interpolator_unit.sv =====
// Velocity setpoint ramp. A request on the input channel (i_in_valid /
// o_in_ready) carries a six-channel velocity target. For it the block sends
// n = step_count requests on the output channel (o_out_valid / i_out_ready),
// each channel moving linearly from the previous target to the new one; the
// last one equals the target and has o_final_step set. A step count above
// MAX_STEPS is taken as MAX_STEPS; a step count of zero sends nothing and
// simply replaces the previous target.
// The user must write the step count through i_cfg_we / i_cfg_data only while
// idle; the block itself does not enforce this. It is sampled when a target is taken.
// After a target is taken, a bit-serial divider per channel runs first; then
// one setpoint follows per cycle while the receiver does not stall, and the
// next target is taken only after the last setpoint of the ramp has been
// registered for output.
// When the receiver stalls, the held result stays unchanged and the ramp
// pauses. Reset clears the previous target to zero, sets the step count to
// 10 and drops any run in progress.
module velocity_setpoint_interpolator_unit #(
    parameter int MAX_STEPS   = 64,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [vspi_pkg::STEP_COUNT_W-1:0]    i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [VALUE_WIDTH-1:0]        i_target_lin_x,
    input  logic signed [VALUE_WIDTH-1:0]        i_target_lin_y,
    input  logic signed [VALUE_WIDTH-1:0]        i_target_lin_z,
    input  logic signed [VALUE_WIDTH-1:0]        i_target_ang_x,
    input  logic signed [VALUE_WIDTH-1:0]        i_target_ang_y,
    input  logic signed [VALUE_WIDTH-1:0]        i_target_ang_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [VALUE_WIDTH-1:0]        o_out_lin_x,
    output logic signed [VALUE_WIDTH-1:0]        o_out_lin_y,
    output logic signed [VALUE_WIDTH-1:0]        o_out_lin_z,
    output logic signed [VALUE_WIDTH-1:0]        o_out_ang_x,
    output logic signed [VALUE_WIDTH-1:0]        o_out_ang_y,
    output logic signed [VALUE_WIDTH-1:0]        o_out_ang_z,
    output logic                                 o_final_step
);

    localparam int NW   = $clog2(MAX_STEPS + 1);
    localparam int DW   = VALUE_WIDTH + 1;
    localparam int CNTW = $clog2(DW);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_STEP = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [vspi_pkg::STEP_COUNT_W-1:0] r_step_count;
    logic [NW-1:0]   r_n;
    logic [NW-1:0]   r_left, n_left;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_out_valid;
    logic            r_final;
    logic [VALUE_WIDTH-1:0] r_out [vspi_pkg::NUM_CH];

    logic [NW-1:0]          w_n_sat;
    logic                   w_accept;
    logic                   w_step;
    logic                   w_last;
    vspi_pkg::t_lane_ctrl   w_ctrl;
    logic signed [VALUE_WIDTH-1:0] w_tgt [vspi_pkg::NUM_CH];
    logic [VALUE_WIDTH-1:0] w_value [vspi_pkg::NUM_CH];

    assign w_tgt[0] = i_target_lin_x;
    assign w_tgt[1] = i_target_lin_y;
    assign w_tgt[2] = i_target_lin_z;
    assign w_tgt[3] = i_target_ang_x;
    assign w_tgt[4] = i_target_ang_y;
    assign w_tgt[5] = i_target_ang_z;

    // Step count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= vspi_pkg::STEP_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_step_count <= i_cfg_data;
        end
    end

    // Step count limited to the largest ramp the block supports.
    assign w_n_sat = (int'(r_step_count) > MAX_STEPS) ? NW'(MAX_STEPS) : NW'(r_step_count);

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_step     = (r_state == S_STEP) && (!r_out_valid || i_out_ready);
    assign w_last     = (r_left == NW'(1));

    // Strobes to the channel lanes.
    always_comb begin
        w_ctrl          = '0;
        w_ctrl.load     = w_accept;
        w_ctrl.bypass   = (w_n_sat == '0);
        w_ctrl.div_step = (r_state == S_DIV);
        w_ctrl.step     = w_step;
        w_ctrl.commit   = w_step && w_last;
    end

    // Sequencer: divide, then emit one setpoint per free output slot.
    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (w_n_sat != '0)) begin
                    n_state = S_DIV;
                    n_left  = w_n_sat;
                    n_cnt   = CNTW'(DW - 1);
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_STEP;
                end else begin
                    n_cnt = r_cnt - CNTW'(1);
                end
            end
            S_STEP: begin
                if (w_step) begin
                    n_left = r_left - NW'(1);
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_cnt   <= n_cnt;
        end
    end

    // The step count of the run in progress.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_n <= w_n_sat;
        end
    end

    // Channel lanes.
    for (genvar g = 0; g < vspi_pkg::NUM_CH; g++) begin : g_lane
        vspi_lane #(
            .VW (VALUE_WIDTH),
            .NW (NW)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_n      (r_n),
            .i_target (w_tgt[g]),
            .o_value  (w_value[g])
        );
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out   <= w_value;
            r_final <= w_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_lin_x  = r_out[0];
    assign o_out_lin_y  = r_out[1];
    assign o_out_lin_z  = r_out[2];
    assign o_out_ang_x  = r_out[3];
    assign o_out_ang_y  = r_out[4];
    assign o_out_ang_z  = r_out[5];
    assign o_final_step = r_final;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int NUM_CH         = vspi_pkg::NUM_CH;
    localparam int STEP_COUNT_W   = vspi_pkg::STEP_COUNT_W;
    localparam int MAX_STEPS      = 64;
    localparam int VALUE_WIDTH    = 16;
    localparam int CFG_SETTLE     = 2 * VALUE_WIDTH + 8;
    localparam int DRAIN_CYCLES   = 4 * VALUE_WIDTH;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_REPORTS    = 40;

    localparam logic [STEP_COUNT_W-1:0] STEP_NONE    = '0;
    localparam logic [STEP_COUNT_W-1:0] STEP_SINGLE  = 7'd1;
    localparam logic [STEP_COUNT_W-1:0] STEP_FULL    = STEP_COUNT_W'(MAX_STEPS);
    localparam logic [STEP_COUNT_W-1:0] STEP_OVER    = STEP_COUNT_W'(MAX_STEPS + 1);
    localparam logic [STEP_COUNT_W-1:0] STEP_REG_MAX = '1;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef logic signed [VALUE_WIDTH-1:0] t_vel_vec [NUM_CH];

    typedef struct {
        t_vel_vec v;
        logic     is_final;
    } t_setpoint;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [STEP_COUNT_W-1:0]   i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    t_vel_vec                  tgt_drive;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [VALUE_WIDTH-1:0] o_out_lin_x, o_out_lin_y, o_out_lin_z;
    logic signed [VALUE_WIDTH-1:0] o_out_ang_x, o_out_ang_y, o_out_ang_z;
    logic                      o_final_step;

    // Predictor state: the step count as last written and the previous target.
    logic [STEP_COUNT_W-1:0]   step_cfg;
    t_vel_vec                  prev_sp;
    t_setpoint                 setpoint_q[$];

    int  err_count;
    bit  idle_en;
    int  hold_req;

    string ch_name [NUM_CH] = '{"lin_x", "lin_y", "lin_z", "ang_x", "ang_y", "ang_z"};

    velocity_setpoint_interpolator_unit #(
        .MAX_STEPS   (MAX_STEPS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_target_lin_x (tgt_drive[0]),
        .i_target_lin_y (tgt_drive[1]),
        .i_target_lin_z (tgt_drive[2]),
        .i_target_ang_x (tgt_drive[3]),
        .i_target_ang_y (tgt_drive[4]),
        .i_target_ang_z (tgt_drive[5]),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_lin_x    (o_out_lin_x),
        .o_out_lin_y    (o_out_lin_y),
        .o_out_lin_z    (o_out_lin_z),
        .o_out_ang_x    (o_out_ang_x),
        .o_out_ang_y    (o_out_ang_y),
        .o_out_ang_z    (o_out_ang_z),
        .o_final_step   (o_final_step)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_count < MAX_REPORTS)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // Works out the whole ramp for one accepted target and queues it.
    function automatic void predict_ramp(input t_vel_vec tgt);
        int        n;
        longint    delta;
        t_setpoint sp;
        n = (step_cfg > MAX_STEPS) ? MAX_STEPS : int'(step_cfg);
        for (int k = 1; k <= n; k++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                delta   = longint'(tgt[c]) - longint'(prev_sp[c]);
                sp.v[c] = VALUE_WIDTH'(longint'(prev_sp[c]) + (k * delta) / n);
            end
            sp.is_final = (k == n);
            setpoint_q.push_back(sp);
        end
        prev_sp = tgt;
    endfunction

    // Checks each setpoint taken by the receiver, then predicts any target accepted.
    always @(posedge i_clk) begin
        t_setpoint want;
        t_vel_vec  got;
        if (i_rst_n) begin
            got = '{o_out_lin_x, o_out_lin_y, o_out_lin_z,
                    o_out_ang_x, o_out_ang_y, o_out_ang_z};
            if (o_out_valid && i_out_ready) begin
                if (setpoint_q.size() == 0) begin
                    report_mismatch("unexpected setpoint (final flag)", o_final_step, 0);
                end else begin
                    want = setpoint_q.pop_front();
                    for (int c = 0; c < NUM_CH; c++)
                        if (got[c] !== want.v[c])
                            report_mismatch(ch_name[c], got[c], want.v[c]);
                    if (o_final_step !== want.is_final)
                        report_mismatch("final_step", o_final_step, want.is_final);
                end
            end
            if (i_in_valid && o_in_ready)
                predict_ramp(tgt_drive);
        end
    end

    // Receiver: random stall bursts, plus a long hold-off when one is requested.
    initial begin
        int hold_left;
        int stall_left;
        hold_left   = 0;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left  = $urandom_range(1, 10) - 1;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Offers one target and waits until it is taken. Called and returns at a falling edge;
    // valid is left high so that a following request can go back to back.
    task automatic send_target(input t_vel_vec tgt);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        tgt_drive  = tgt;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Drops the request line and waits until the block has finished all its work.
    task automatic settle_idle();
        i_in_valid = 1'b0;
        while (setpoint_q.size() != 0) @(negedge i_clk);
        repeat (CFG_SETTLE) @(negedge i_clk);
    endtask

    // Writes the step count register while the block is idle.
    task automatic write_step_count(input logic [STEP_COUNT_W-1:0] val);
        settle_idle();
        i_cfg_we   = 1'b1;
        i_cfg_data = val;
        step_cfg   = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        i_cfg_data = STEP_COUNT_W'($urandom());
    endtask

    function automatic t_vel_vec fill_vec(input logic signed [VALUE_WIDTH-1:0] val);
        t_vel_vec v;
        for (int c = 0; c < NUM_CH; c++)
            v[c] = val;
        return v;
    endfunction

    // Mostly uniform values, with the range ends and small values mixed in.
    function automatic t_vel_vec random_target();
        t_vel_vec v;
        for (int c = 0; c < NUM_CH; c++) begin
            case ($urandom_range(0, 9))
                0:       v[c] = VAL_MAX;
                1:       v[c] = VAL_MIN;
                2:       v[c] = VALUE_WIDTH'(int'($urandom_range(0, 40)) - 20);
                default: v[c] = VALUE_WIDTH'($urandom());
            endcase
        end
        return v;
    endfunction

    // Range extremes, full-scale swings and truncation at the reset step count.
    task automatic test_extremes();
        send_target(fill_vec(VAL_MAX));
        send_target(fill_vec(VAL_MIN));
        send_target(fill_vec('0));
        send_target('{VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN});
        send_target('{VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX});
        send_target('{16'sd5, -16'sd5, 16'sd1, -16'sd1, 16'sd9, -16'sd9});
        send_target('{-16'sd3, 16'sd7, 16'sd0, -16'sd1, 16'sd11, -16'sd13});
    endtask

    // Single step, full length, saturation above the limit and the zero count.
    task automatic test_step_count_edges();
        write_step_count(STEP_SINGLE);
        send_target(fill_vec(VAL_MAX));
        send_target('{16'sd100, -16'sd100, VAL_MIN, 16'sd0, 16'sd1, -16'sd1});
        write_step_count(STEP_FULL);
        send_target(fill_vec(VAL_MIN));
        send_target('{VAL_MAX, 16'sd63, -16'sd63, 16'sd1, -16'sd1, 16'sd0});
        write_step_count(STEP_REG_MAX);
        send_target(fill_vec(VAL_MAX));
        write_step_count(STEP_OVER);
        send_target('{VAL_MIN, VAL_MAX, 16'sd7, -16'sd7, 16'sd0, 16'sd1000});
        // A zero count emits nothing, but the next ramp must start from the skipped target.
        write_step_count(STEP_NONE);
        send_target('{16'sd1234, -16'sd4321, VAL_MAX, VAL_MIN, 16'sd0, -16'sd1});
        send_target('{-16'sd20, 16'sd20, 16'sd0, 16'sd3, VAL_MAX, VAL_MIN});
        write_step_count(7'd3);
        send_target(fill_vec('0));
    endtask

    // The receiver holds off for a long stretch while targets keep coming.
    task automatic test_backpressure();
        write_step_count(7'd4);
        hold_req = HOLD_CYCLES;
        repeat (8) send_target(random_target());
    endtask

    // Random targets in phases, each at a random step count, mostly short ramps.
    task automatic test_random_ramps(input int phases, input int per_phase, input bit idle);
        logic [STEP_COUNT_W-1:0] cnt;
        for (int p = 0; p < phases; p++) begin
            case ($urandom_range(0, 15))
                0:       cnt = STEP_NONE;
                1:       cnt = STEP_FULL;
                2:       cnt = STEP_REG_MAX;
                3:       cnt = STEP_COUNT_W'($urandom_range(MAX_STEPS + 1, 127));
                4:       cnt = STEP_COUNT_W'($urandom_range(9, MAX_STEPS - 1));
                default: cnt = STEP_COUNT_W'($urandom_range(1, 8));
            endcase
            write_step_count(cnt);
            idle_en = idle;
            repeat (per_phase) send_target(random_target());
        end
    endtask

    // Test sequence.
    initial begin
        err_count  = 0;
        idle_en    = 1'b1;
        hold_req   = 0;
        step_cfg   = vspi_pkg::STEP_COUNT_RESET;
        prev_sp    = fill_vec('0);
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        tgt_drive  = fill_vec('0);
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        test_step_count_edges();
        test_backpressure();
        test_random_ramps(20, 12, 1'b1);
        test_random_ramps(4, 12, 1'b0);

        // Wait for the last ramp, then watch for stray setpoints.
        idle_en    = 1'b0;
        i_in_valid = 1'b0;
        while (setpoint_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== velocity_setpoint_interpolator_unit.f =====
hw/rtl/vspi_pkg.sv
hw/rtl/vspi_div.sv
hw/rtl/vspi_lane.sv
hw/rtl/velocity_setpoint_interpolator_unit.sv
sim/tb_top.sv
